[rtl/core/slp_pkg.sv]
`timescale 1ns / 1ps
// slp_pkg: widths, schedule codes and beat types for static_loop_partition.
// No dependencies; used by slp_udiv and static_loop_partition.
package slp_pkg;

    localparam int unsigned IDX_W       = 32;
    localparam int unsigned CMD_W       = 6;
    localparam int unsigned TID_W       = 6;
    localparam int unsigned NTH_W       = 7;
    localparam int unsigned MAX_THREADS = 64;
    localparam int unsigned DIV_STEPS   = IDX_W;

    localparam logic [CMD_W-1:0] SCHED_CHUNKED  = 6'd33;
    localparam logic [CMD_W-1:0] SCHED_BALANCED = 6'd34;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TID_W-1:0]  thread_index;
        logic signed [31:0] loop_lower;
        logic signed [31:0] loop_upper;
        logic signed [31:0] loop_step;
        logic signed [31:0] chunk_size;
    } slp_in_t;

    typedef struct packed {
        logic signed [31:0] part_lower;
        logic signed [31:0] part_upper;
        logic signed [31:0] part_stride;
        logic               is_last;
        logic               bad_schedule;
    } slp_out_t;

    // request state that travels down the divider stages
    typedef struct packed {
        logic              vld;
        logic [CMD_W-1:0]  cmd;
        logic [TID_W-1:0]  tid;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  up;
        logic [IDX_W-1:0]  step;
        logic [IDX_W-1:0]  chunk;
        logic [NTH_W-1:0]  nth;
        logic [IDX_W-1:0]  trip;
        logic [IDX_W-1:0]  small_q;
        logic [NTH_W-1:0]  extras;
    } slp_pipe_t;

    // request state plus products and sums of the closing stages
    typedef struct packed {
        slp_pipe_t        base;
        logic             last_c;
        logic             less;
        logic             trip_lt;
        logic [NTH_W-1:0] shift;
        logic [IDX_W-1:0] span;
        logic [IDX_W-1:0] ts;
        logic [IDX_W-1:0] m1;
        logic [IDX_W-1:0] stride_c;
        logic [IDX_W-1:0] ofs_c;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] sm_step;
        logic [IDX_W-1:0] lo_t;
        logic [IDX_W-1:0] ofs_b;
        logic [IDX_W-1:0] lo_c;
        logic [IDX_W-1:0] sm_adj;
        logic [IDX_W-1:0] lo_b;
        logic [IDX_W-1:0] up_c;
        logic [IDX_W-1:0] one_str;
    } slp_post_t;

endpackage

[rtl/core/slp_udiv.sv]
`timescale 1ns / 1ps
// slp_udiv: pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on slp_pkg. The load stage and the per-bit stages advance only while en is high; divisor 0 gives all ones.
module slp_udiv (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [slp_pkg::IDX_W-1:0] dividend,
    input  logic [slp_pkg::IDX_W-1:0] divisor,
    output logic [slp_pkg::IDX_W-1:0] quotient,
    output logic [slp_pkg::IDX_W-1:0] remainder
);

    logic [slp_pkg::IDX_W-1:0] rem_reg [0:slp_pkg::DIV_STEPS];
    logic [slp_pkg::IDX_W-1:0] num_reg [0:slp_pkg::DIV_STEPS];
    logic [slp_pkg::IDX_W-1:0] quo_reg [0:slp_pkg::DIV_STEPS];
    logic [slp_pkg::IDX_W-1:0] den_reg [0:slp_pkg::DIV_STEPS];

    // load stage
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            num_reg[0] <= dividend;
            quo_reg[0] <= '0;
            den_reg[0] <= divisor;
        end
    end

    // one shift-compare-subtract per stage
    for (genvar g = 1; g <= slp_pkg::DIV_STEPS; g++) begin : g_step
        logic [slp_pkg::IDX_W:0]   trial;
        logic                      ge;
        logic [slp_pkg::IDX_W-1:0] rem_next;

        always_comb begin
            trial    = {rem_reg[g-1], num_reg[g-1][slp_pkg::IDX_W-1]};
            ge       = (trial >= {1'b0, den_reg[g-1]});
            rem_next = ge ? slp_pkg::IDX_W'(trial - {1'b0, den_reg[g-1]})
                          : trial[slp_pkg::IDX_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= rem_next;
                num_reg[g] <= {num_reg[g-1][slp_pkg::IDX_W-2:0], 1'b0};
                quo_reg[g] <= {quo_reg[g-1][slp_pkg::IDX_W-2:0], ge};
                den_reg[g] <= den_reg[g-1];
            end
        end
    end

    assign quotient  = quo_reg[slp_pkg::DIV_STEPS];
    assign remainder = rem_reg[slp_pkg::DIV_STEPS];

endmodule

[rtl/core/static_loop_partition.sv]
`timescale 1ns / 1ps
// static_loop_partition: static work-sharing of one loop for one thread of a team.
// Depends on slp_pkg and slp_udiv.
//
//   channel | direction | handshake          | beat
//   s_      | in        | s_valid / s_ready  | slp_in_t
//   m_      | out       | m_valid / m_ready  | slp_out_t
//   cfg_    | in        | cfg_wr_en          | team_size, 7 bits
//
// One beat per cycle enters while the output is not held; the path is the input stage, three
// 33-stage divider pipelines (trip count, then quotient pair, then modulo by
// team size), four multiply/add stages and the output register.
// Reset clears all valid bits and sets team_size to 1.
// A held output stalls every stage at once; s_ready falls only then.
module static_loop_partition (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  slp_pkg::slp_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output slp_pkg::slp_out_t                 m_data,
    input  logic                              cfg_wr_en,
    input  logic [slp_pkg::NTH_W-1:0]         cfg_wr_data
);

    localparam int unsigned W  = slp_pkg::IDX_W;
    localparam int unsigned DL = slp_pkg::DIV_STEPS;

    logic                       en;
    logic [slp_pkg::NTH_W-1:0]  team_size_reg;
    slp_pkg::slp_pipe_t         s0_reg, s0_next;
    logic [W-1:0]               s0_dist_reg, s0_dist_next;
    logic [W-1:0]               s0_den_reg, s0_den_next;
    slp_pkg::slp_pipe_t         pa_reg [0:DL];
    slp_pkg::slp_pipe_t         pb_reg [0:DL];
    slp_pkg::slp_pipe_t         pc_reg [0:DL];
    slp_pkg::slp_pipe_t         pb0_next, pc0_next;
    logic [W-1:0]               qa, ra, qb, rb, qd, rd, qc, rc;
    logic [W-1:0]               trip_a;
    slp_pkg::slp_post_t         q1_reg, q1_next, q2_reg, q2_next;
    slp_pkg::slp_post_t         q3_reg, q3_next, q4_reg, q4_next;
    slp_pkg::slp_out_t          out_reg, out_next;
    logic                       m_valid_reg;

    // global advance: whole pipe moves unless the output beat is held
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // team size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            team_size_reg <= slp_pkg::NTH_W'(1);
        end else if (cfg_wr_en) begin
            team_size_reg <= cfg_wr_data;
        end
    end

    // input stage: clamp team size and chunk, distance and divisor magnitude
    always_comb begin
        logic step_pos;
        step_pos = !s_data.loop_step[W-1] && (s_data.loop_step != '0);
        s0_next         = '0;
        s0_next.vld     = s_valid;
        s0_next.cmd     = s_data.cmd;
        s0_next.tid     = s_data.thread_index;
        s0_next.lo      = s_data.loop_lower;
        s0_next.up      = s_data.loop_upper;
        s0_next.step    = s_data.loop_step;
        s0_next.chunk   = (s_data.chunk_size[W-1] || s_data.chunk_size == '0)
                          ? W'(1) : s_data.chunk_size;
        if (team_size_reg == '0) begin
            s0_next.nth = slp_pkg::NTH_W'(1);
        end else if (team_size_reg > slp_pkg::NTH_W'(slp_pkg::MAX_THREADS)) begin
            s0_next.nth = slp_pkg::NTH_W'(slp_pkg::MAX_THREADS);
        end else begin
            s0_next.nth = team_size_reg;
        end
        s0_dist_next = step_pos ? W'(s_data.loop_upper - s_data.loop_lower)
                                : W'(s_data.loop_lower - s_data.loop_upper);
        s0_den_next  = step_pos ? W'(s_data.loop_step) : W'(W'(0) - s_data.loop_step);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_reg.vld <= 1'b0;
        end else if (en) begin
            s0_reg      <= s0_next;
            s0_dist_reg <= s0_dist_next;
            s0_den_reg  <= s0_den_next;
        end
    end

    // trip count division: distance / |step|
    slp_udiv u_div_trip (
        .aclk      (aclk),
        .en        (en),
        .dividend  (s0_dist_reg),
        .divisor   (s0_den_reg),
        .quotient  (qa),
        .remainder (ra)
    );

    assign trip_a = W'(qa + W'(1));

    // chunk index of the final iteration: (trip - 1) / chunk
    slp_udiv u_div_chunk (
        .aclk      (aclk),
        .en        (en),
        .dividend  (qa),
        .divisor   (pa_reg[DL].chunk),
        .quotient  (qb),
        .remainder (rb)
    );

    // balanced share: trip / team size and trip % team size
    slp_udiv u_div_share (
        .aclk      (aclk),
        .en        (en),
        .dividend  (trip_a),
        .divisor   (W'(pa_reg[DL].nth)),
        .quotient  (qd),
        .remainder (rd)
    );

    // owner of the final chunk: chunk index % team size
    slp_udiv u_div_owner (
        .aclk      (aclk),
        .en        (en),
        .dividend  (qb),
        .divisor   (W'(pb_reg[DL].nth)),
        .quotient  (qc),
        .remainder (rc)
    );

    always_comb begin
        pb0_next      = pa_reg[DL];
        pb0_next.trip = trip_a;
        pc0_next         = pb_reg[DL];
        pc0_next.small_q = qd;
        pc0_next.extras  = rd[slp_pkg::NTH_W-1:0];
    end

    // request state delay lines matched to the dividers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= DL; i++) begin
                pa_reg[i].vld <= 1'b0;
                pb_reg[i].vld <= 1'b0;
                pc_reg[i].vld <= 1'b0;
            end
        end else if (en) begin
            pa_reg[0] <= s0_reg;
            pb_reg[0] <= pb0_next;
            pc_reg[0] <= pc0_next;
            for (int i = 1; i <= DL; i++) begin
                pa_reg[i] <= pa_reg[i-1];
                pb_reg[i] <= pb_reg[i-1];
                pc_reg[i] <= pc_reg[i-1];
            end
        end
    end

    // stage 1: chunk span, first products, compares
    always_comb begin
        logic [W-1:0] tid_w;
        tid_w           = W'(pc_reg[DL].tid);
        q1_next         = '0;
        q1_next.base    = pc_reg[DL];
        q1_next.last_c  = (tid_w == rc);
        q1_next.span    = W'(pc_reg[DL].chunk * pc_reg[DL].step);
        q1_next.ts      = W'(tid_w * pc_reg[DL].step);
        q1_next.m1      = W'(tid_w * pc_reg[DL].small_q);
        q1_next.less    = (slp_pkg::NTH_W'(pc_reg[DL].tid) < pc_reg[DL].extras);
        q1_next.shift   = q1_next.less ? slp_pkg::NTH_W'(pc_reg[DL].tid)
                                       : pc_reg[DL].extras;
        q1_next.trip_lt = (pc_reg[DL].trip < W'(pc_reg[DL].nth));
    end

    // stage 2: stride, chunk offset, balanced index, small * step, tid lower bound
    always_comb begin
        q2_next          = q1_reg;
        q2_next.stride_c = W'(q1_reg.span * W'(q1_reg.base.nth));
        q2_next.ofs_c    = W'(q1_reg.span * W'(q1_reg.base.tid));
        q2_next.k        = W'(q1_reg.m1 + W'(q1_reg.shift));
        q2_next.sm_step  = W'(q1_reg.base.small_q * q1_reg.base.step);
        q2_next.lo_t     = W'(q1_reg.base.lo + q1_reg.ts);
    end

    // stage 3: balanced offset, chunked lower bound, adjusted balanced span
    always_comb begin
        q3_next        = q2_reg;
        q3_next.ofs_b  = W'(q2_reg.base.step * q2_reg.k);
        q3_next.lo_c   = W'(q2_reg.base.lo + q2_reg.ofs_c);
        q3_next.sm_adj = q2_reg.less ? q2_reg.sm_step
                                     : W'(q2_reg.sm_step - q2_reg.base.step);
    end

    // stage 4: balanced lower bound, chunked upper bound, team-of-one stride
    always_comb begin
        logic step_pos;
        step_pos        = !q3_reg.base.step[W-1] && (q3_reg.base.step != '0);
        q4_next         = q3_reg;
        q4_next.lo_b    = W'(q3_reg.base.lo + q3_reg.ofs_b);
        q4_next.up_c    = W'(q3_reg.lo_c + q3_reg.span - q3_reg.base.step);
        q4_next.one_str = step_pos ? W'(q3_reg.base.up - q3_reg.base.lo + W'(1))
                                   : W'(q3_reg.base.up - q3_reg.base.lo - W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q1_reg.base.vld <= 1'b0;
            q2_reg.base.vld <= 1'b0;
            q3_reg.base.vld <= 1'b0;
            q4_reg.base.vld <= 1'b0;
        end else if (en) begin
            q1_reg <= q1_next;
            q2_reg <= q2_next;
            q3_reg <= q3_next;
            q4_reg <= q4_next;
        end
    end

    // result select by team size and schedule
    always_comb begin
        logic [W-1:0] tid_w;
        tid_w    = W'(q4_reg.base.tid);
        out_next = '0;
        out_next.part_lower = q4_reg.base.lo;
        out_next.part_upper = q4_reg.base.up;
        if (q4_reg.base.nth == slp_pkg::NTH_W'(1)) begin
            out_next.part_stride = q4_reg.one_str;
            out_next.is_last     = 1'b1;
        end else begin
            case (q4_reg.base.cmd)
                slp_pkg::SCHED_CHUNKED: begin
                    out_next.part_lower  = q4_reg.lo_c;
                    out_next.part_upper  = q4_reg.up_c;
                    out_next.part_stride = q4_reg.stride_c;
                    out_next.is_last     = q4_reg.last_c;
                end
                slp_pkg::SCHED_BALANCED: begin
                    out_next.part_stride = q4_reg.base.trip;
                    if (q4_reg.trip_lt) begin
                        if (tid_w < q4_reg.base.trip) begin
                            out_next.part_lower = q4_reg.lo_t;
                            out_next.part_upper = q4_reg.lo_t;
                        end else begin
                            out_next.part_lower = W'(q4_reg.base.up + q4_reg.base.step);
                        end
                        out_next.is_last = (tid_w == W'(q4_reg.base.trip - W'(1)));
                    end else begin
                        out_next.part_lower = q4_reg.lo_b;
                        out_next.part_upper = W'(q4_reg.lo_b + q4_reg.sm_adj);
                        out_next.is_last    = (slp_pkg::NTH_W'(q4_reg.base.tid) ==
                                               slp_pkg::NTH_W'(q4_reg.base.nth - 1'b1));
                    end
                end
                default: begin
                    out_next.bad_schedule = 1'b1;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= q4_reg.base.vld;
            out_reg     <= out_next;
        end
    end

endmodule

[sim/tb_static_loop_partition.sv]
`timescale 1ns / 1ps
// tb_static_loop_partition: self-checking bench for static_loop_partition.
// Predicts each thread's share of the loop and compares every output beat.
// Depends on slp_pkg and the static_loop_partition RTL.
module tb_static_loop_partition;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 120;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    slp_pkg::slp_in_t           s_data = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    slp_pkg::slp_out_t          m_data;
    logic                       cfg_wr_en = 1'b0;
    logic [slp_pkg::NTH_W-1:0]  cfg_wr_data = '0;

    slp_pkg::slp_out_t          share_q[$];
    logic [slp_pkg::NTH_W-1:0]  team_reg = 7'd1;
    bit                         idle_on = 1'b1;
    int                         err_count = 0;
    int                         quiet_cycles = 0;

    always #5 aclk = ~aclk;

    static_loop_partition DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // unsigned divide, all ones on a zero divisor
    function automatic logic [31:0] udiv_wrap(logic [31:0] a, logic [31:0] b);
        if (b == 32'd0) return 32'hFFFF_FFFF;
        return a / b;
    endfunction

    // this thread's share of the loop for the given team size
    function automatic slp_pkg::slp_out_t thread_share(slp_pkg::slp_in_t req,
                                                       logic [slp_pkg::NTH_W-1:0] team);
        slp_pkg::slp_out_t r;
        logic [31:0] lo, up, st, ch, nth, tid, trip, span, small_n, extras, shift;
        bit          pos;
        lo  = req.loop_lower;
        up  = req.loop_upper;
        st  = req.loop_step;
        ch  = req.chunk_size;
        tid = {26'd0, req.thread_index};
        pos = !st[31] && st != 32'd0;
        nth = {25'd0, team};
        if (nth == 0) nth = 1;
        if (nth > slp_pkg::MAX_THREADS) nth = slp_pkg::MAX_THREADS;
        r = '0;
        if (nth == 1) begin
            r.is_last     = 1'b1;
            r.part_stride = pos ? up - lo + 32'd1 : up - lo - 32'd1;
        end else begin
            if (st == 32'd1) trip = up - lo + 32'd1;
            else if (st == 32'hFFFF_FFFF) trip = lo - up + 32'd1;
            else if (pos) trip = udiv_wrap(up - lo, st) + 32'd1;
            else trip = udiv_wrap(lo - up, 32'd0 - st) + 32'd1;

            if (req.cmd == slp_pkg::SCHED_CHUNKED) begin
                if (ch[31] || ch == 32'd0) ch = 32'd1;
                span = ch * st;
                r.part_stride = span * nth;
                lo = lo + span * tid;
                up = lo + span - st;
                r.is_last = (tid == udiv_wrap(trip - 32'd1, ch) % nth);
            end else if (req.cmd == slp_pkg::SCHED_BALANCED) begin
                if (trip < nth) begin
                    if (tid < trip) begin
                        lo = lo + tid * st;
                        up = lo;
                    end else begin
                        lo = up + st;
                    end
                    r.is_last = (tid == trip - 32'd1);
                end else begin
                    small_n = trip / nth;
                    extras  = trip % nth;
                    shift   = (tid < extras) ? tid : extras;
                    lo = lo + st * (tid * small_n + shift);
                    up = lo + small_n * st - ((tid < extras) ? 32'd0 : st);
                    r.is_last = (tid == nth - 32'd1);
                end
                r.part_stride = trip;
            end else begin
                r.bad_schedule = 1'b1;
            end
        end
        r.part_lower = lo;
        r.part_upper = up;
        return r;
    endfunction

    task automatic report_err(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    // result side: random back-pressure while idle_on is set, else always ready
    always @(posedge aclk) begin
        m_ready <= idle_on ? ($urandom_range(99) >= 16) : 1'b1;
    end

    // check every accepted output beat against the oldest prediction
    always @(posedge aclk) begin
        slp_pkg::slp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (share_q.size() == 0) begin
                report_err("output beat with nothing expected");
            end else begin
                want = share_q.pop_front();
                if (m_data.part_lower !== want.part_lower)
                    report_err($sformatf("part_lower %h want %h",
                                         m_data.part_lower, want.part_lower));
                if (m_data.part_upper !== want.part_upper)
                    report_err($sformatf("part_upper %h want %h",
                                         m_data.part_upper, want.part_upper));
                if (m_data.part_stride !== want.part_stride)
                    report_err($sformatf("part_stride %h want %h",
                                         m_data.part_stride, want.part_stride));
                if (m_data.is_last !== want.is_last)
                    report_err($sformatf("is_last %b want %b",
                                         m_data.is_last, want.is_last));
                if (m_data.bad_schedule !== want.bad_schedule)
                    report_err($sformatf("bad_schedule %b want %b",
                                         m_data.bad_schedule, want.bad_schedule));
            end
        end
    end

    // watchdog: cycles without any handshake or register write
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // send one beat; valid stays high on return so beats can go back to back
    task automatic send_beat(input slp_pkg::slp_in_t req);
        if (idle_on && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        share_q.push_back(thread_share(req, team_reg));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (share_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_team(input logic [slp_pkg::NTH_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        team_reg = value;
    endtask

    function automatic slp_pkg::slp_in_t make_req(logic [5:0] cmd, logic [5:0] tid,
                                                  int lo, int up, int st, int ch);
        slp_pkg::slp_in_t r;
        r.cmd = cmd;
        r.thread_index = tid;
        r.loop_lower = lo;
        r.loop_upper = up;
        r.loop_step  = st;
        r.chunk_size = ch;
        return r;
    endfunction

    function automatic int pick_bound();
        case ($urandom_range(3))
            0: return int'($urandom());
            1: return int'($urandom_range(200)) - 100;
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom_range(1) ? 0 : -1;
        endcase
    endfunction

    function automatic int pick_step();
        case ($urandom_range(7))
            0: return 1;
            1: return -1;
            2: return int'($urandom_range(9)) + 2;
            3: return -int'($urandom_range(9)) - 2;
            4: return int'($urandom());
            5: return ($urandom_range(9) == 0) ? 0 : 3;
            default: return int'($urandom_range(40)) - 20;
        endcase
    endfunction

    // mostly well-formed loops; some full-range noise and bad codes
    function automatic slp_pkg::slp_in_t random_req(logic [slp_pkg::NTH_W-1:0] team);
        int lo, st, ch, span;
        logic [5:0] cmd, tid;
        lo = pick_bound();
        st = pick_step();
        span = int'($urandom_range(300));
        case ($urandom_range(9))
            0: cmd = 6'($urandom());
            1, 2, 3, 4: cmd = slp_pkg::SCHED_CHUNKED;
            default: cmd = slp_pkg::SCHED_BALANCED;
        endcase
        tid = ($urandom_range(4) == 0 || team == 0) ? 6'($urandom())
                                                    : 6'($urandom_range(team - 1));
        case ($urandom_range(3))
            0: ch = int'($urandom());
            1: ch = -int'($urandom_range(3));
            default: ch = int'($urandom_range(16));
        endcase
        if ($urandom_range(7) == 0)
            return make_req(cmd, tid, lo, int'($urandom()), st, ch);
        return make_req(cmd, tid, lo, (st < 0) ? lo - span : lo + span, st, ch);
    endfunction

    task automatic test_single_thread();
        write_team(7'd1);
        send_beat(make_req(slp_pkg::SCHED_CHUNKED, 6'd0, 0, 99, 1, 4));
        send_beat(make_req(6'd5, 6'd63, 32'h8000_0000, 32'h7FFF_FFFF, -1, 0));
        send_beat(make_req(slp_pkg::SCHED_BALANCED, 6'd3, 10, -10, 0, 1));
    endtask

    task automatic test_directed_team();
        write_team(7'd4);
        send_beat(make_req(slp_pkg::SCHED_CHUNKED, 6'd1, 0, 99, 1, 4));
        send_beat(make_req(slp_pkg::SCHED_CHUNKED, 6'd2, 0, 99, 1, 0));     // chunk 0 -> 1
        send_beat(make_req(slp_pkg::SCHED_CHUNKED, 6'd3, 100, 0, -3, -5));  // negative chunk
        send_beat(make_req(slp_pkg::SCHED_BALANCED, 6'd0, 0, 10, 1, 1));    // remainder to low
        send_beat(make_req(slp_pkg::SCHED_BALANCED, 6'd3, 0, 10, 1, 1));
        send_beat(make_req(slp_pkg::SCHED_BALANCED, 6'd1, 0, 1, 1, 1));     // fewer iters
        send_beat(make_req(slp_pkg::SCHED_BALANCED, 6'd3, 0, 1, 1, 1));
        send_beat(make_req(slp_pkg::SCHED_BALANCED, 6'd2, 5, 5, 0, 1));     // zero step
        send_beat(make_req(slp_pkg::SCHED_CHUNKED, 6'd2, 5, 5, 0, 2));
        send_beat(make_req(slp_pkg::SCHED_BALANCED, 6'd63, 0, 1000, 7, 1)); // tid past team
        send_beat(make_req(6'd0, 6'd1, 3, 9, 1, 1));                        // bad codes
        send_beat(make_req(6'd63, 6'd0, -1, 0, 2, 2));
        send_beat(make_req(slp_pkg::SCHED_BALANCED, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_beat(make_req(slp_pkg::SCHED_CHUNKED, 6'd2, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000));
        write_team(7'd0);                                                   // treated as 1
        send_beat(make_req(slp_pkg::SCHED_BALANCED, 6'd0, 1, 20, 1, 1));
        write_team(7'd127);                                                 // saturates
        send_beat(make_req(slp_pkg::SCHED_BALANCED, 6'd63, 0, 999, 1, 1));
        send_beat(make_req(slp_pkg::SCHED_CHUNKED, 6'd40, 0, 999, 2, 3));
    endtask

    task automatic test_random();
        logic [slp_pkg::NTH_W-1:0] teams[8];
        teams = '{7'd2, 7'd64, 7'd1, 7'd7, 7'd3, 7'd127, 7'd0, 7'd16};
        foreach (teams[i]) begin
            write_team((i == 7) ? 7'($urandom()) : teams[i]);
            idle_on = (i != 1);      // one phase runs at full rate
            repeat (75) send_beat(random_req(team_reg));
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_thread();
        test_directed_team();
        test_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0 && share_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[static_loop_partition.f]
rtl/core/slp_pkg.sv
rtl/core/slp_udiv.sv
rtl/core/static_loop_partition.sv
sim/tb_static_loop_partition.sv
